// ===== src/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd3;

    // header layout
    localparam logic [DATA_W-1:0] HDR_LEN     = 32'd12;
    localparam logic [DATA_W-1:0] OFF_SIZE    = 32'd0;
    localparam logic [DATA_W-1:0] OFF_NEXT    = 32'd4;
    localparam logic [DATA_W-1:0] OFF_USE     = 32'd8;
    localparam logic [DATA_W-1:0] SPLIT_SLACK = 32'd8;

    localparam logic [PADDR_W-1:0] REG_BASE_ADDR = 2'd0;
    localparam logic [DATA_W-1:0]  BASE_ADDR_RST = 32'd65536;

    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr_req;

endpackage

// ===== src/ffha_chan_if.sv =====
// Request and response channel interfaces of the heap allocator.
interface ffha_req_if;
    logic                       valid;
    logic                       ready;
    logic [ffha_pkg::CMD_W-1:0]  cmd;
    logic [ffha_pkg::DATA_W-1:0] req_size;
    logic [ffha_pkg::DATA_W-1:0] block_addr;

    modport source (output valid, cmd, req_size, block_addr, input ready);
    modport sink   (input valid, cmd, req_size, block_addr, output ready);
endinterface

interface ffha_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ffha_pkg::DATA_W-1:0] alloc_addr;
    logic [ffha_pkg::STAT_W-1:0] status;

    modport source (output valid, alloc_addr, status, input ready);
    modport sink   (input valid, alloc_addr, status, output ready);
endinterface

// ===== src/ffha_store.sv =====
// Heap byte store: four byte-lane memories giving unaligned 32-bit word access.
module ffha_store #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                        i_clk,
    input  ffha_pkg::t_rd_req           i_rd,
    input  ffha_pkg::t_wr_req           i_wr,
    input  logic [ffha_pkg::DATA_W-1:0] i_base,
    output logic [ffha_pkg::DATA_W-1:0] o_rdata
);

    localparam int BANK_DEPTH = (HEAP_BYTES + 3) / 4;
    localparam int IW         = $clog2(BANK_DEPTH);
    localparam logic [ffha_pkg::DATA_W-1:0] HEAP_SZ = 32'(HEAP_BYTES);

    logic [ffha_pkg::DATA_W-1:0] rd_rel;
    logic [ffha_pkg::DATA_W-1:0] wr_rel;
    logic [1:0]                  r_rot;
    logic [7:0]                  lane_q  [4];
    logic                        lane_ok [4];

    assign rd_rel = i_rd.addr - i_base;
    assign wr_rel = i_wr.addr - i_base;

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rot <= rd_rel[1:0];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [1:0]                  rd_pos;
        logic [1:0]                  wr_pos;
        logic [ffha_pkg::DATA_W-1:0] rd_byte;
        logic [ffha_pkg::DATA_W-1:0] wr_byte;
        logic                        rd_in;
        logic                        wr_in;
        logic [7:0]                  r_mem [BANK_DEPTH];
        logic [7:0]                  r_q;
        logic                        r_ok;

        // byte position within the word that falls into this lane
        assign rd_pos  = 2'(k) - rd_rel[1:0];
        assign wr_pos  = 2'(k) - wr_rel[1:0];
        assign rd_byte = rd_rel + {30'd0, rd_pos};
        assign wr_byte = wr_rel + {30'd0, wr_pos};
        assign rd_in   = rd_byte < HEAP_SZ;
        assign wr_in   = wr_byte < HEAP_SZ;

        always_ff @(posedge i_clk) begin
            if (i_wr.en && wr_in) begin
                r_mem[wr_byte[IW+1:2]] <= i_wr.data[{wr_pos, 3'b000} +: 8];
            end
            if (i_rd.en) begin
                r_ok <= rd_in;
                if (rd_in) begin
                    r_q <= r_mem[rd_byte[IW+1:2]];
                end
            end
        end

        assign lane_q[k]  = r_q;
        assign lane_ok[k] = r_ok;
    end

    // bytes outside the store read as zero
    always_comb begin
        logic [1:0] sel;
        sel = 2'd0;
        for (int i = 0; i < 4; i++) begin
            sel = 2'(i) + r_rot;
            o_rdata[8*i +: 8] = lane_ok[sel] ? lane_q[sel] : 8'd0;
        end
    end

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// First-fit free-list heap allocator: command sequencer, config register, result register.
//
//  channel   dir  beat payload                    accepted when
//  i_req     in   cmd, req_size, block_addr       valid && ready
//  o_rsp     out  alloc_addr, status              valid && ready
//  apb       in   base address write / read       psel && penable && pready
//
// Allocate walks the free list, reading the size and link of each header through the
// single store read port, then makes up to 6 word writes. Free checks the in-use word
// before its writes; initialise writes one header. Results sit in an output register.
// Reset empties the free list and restores the base address; the store is not cleared.
// A stalled result holds the sequencer in its final step; i_req is taken only when idle.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ffha_req_if.sink                     i_req,
    ffha_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffha_pkg::PADDR_W-1:0] paddr,
    input  logic [ffha_pkg::DATA_W-1:0]  pwdata,
    output logic [ffha_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int WALK_LIMIT = HEAP_BYTES / 12 + 1;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(WALK_LIMIT);
    localparam logic [32:0] HEAP_SZ_X = 33'(HEAP_BYTES);
    localparam logic [ffha_pkg::DATA_W-1:0] INIT_SIZE = 32'(HEAP_BYTES) - ffha_pkg::HDR_LEN;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_WALK     = 5'd1;
    localparam logic [4:0] S_RD_NEXT  = 5'd2;
    localparam logic [4:0] S_DECIDE   = 5'd3;
    localparam logic [4:0] S_W_PREV   = 5'd4;
    localparam logic [4:0] S_R_SIZE   = 5'd5;
    localparam logic [4:0] S_R_USE    = 5'd6;
    localparam logic [4:0] S_R_NEXT   = 5'd7;
    localparam logic [4:0] S_C_SIZE   = 5'd8;
    localparam logic [4:0] S_C_USE    = 5'd9;
    localparam logic [4:0] S_F_RD     = 5'd10;
    localparam logic [4:0] S_F_CHK    = 5'd11;
    localparam logic [4:0] S_F_USE    = 5'd12;
    localparam logic [4:0] S_F_NEXT   = 5'd13;
    localparam logic [4:0] S_I_SIZE   = 5'd14;
    localparam logic [4:0] S_I_NEXT   = 5'd15;
    localparam logic [4:0] S_I_USE    = 5'd16;
    localparam logic [4:0] S_DONE     = 5'd17;

    logic [4:0]                  r_state,      n_state;
    logic [ffha_pkg::DATA_W-1:0] r_head,       n_head;
    logic [ffha_pkg::DATA_W-1:0] r_base,       n_base;
    logic [ffha_pkg::DATA_W-1:0] r_cur,        n_cur;
    logic [ffha_pkg::DATA_W-1:0] r_prev,       n_prev;
    logic [ffha_pkg::DATA_W-1:0] r_size,       n_size;
    logic [ffha_pkg::DATA_W-1:0] r_bsize,      n_bsize;
    logic [ffha_pkg::DATA_W-1:0] r_nxt,        n_nxt;
    logic [ffha_pkg::DATA_W-1:0] r_rem,        n_rem;
    logic [STEP_W-1:0]           r_steps,      n_steps;
    logic                        r_split,      n_split;
    logic [ffha_pkg::DATA_W-1:0] r_res_addr,   n_res_addr;
    logic [ffha_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic                        r_out_valid,  n_out_valid;
    logic [ffha_pkg::DATA_W-1:0] r_out_addr,   n_out_addr;
    logic [ffha_pkg::STAT_W-1:0] r_out_status, n_out_status;

    ffha_pkg::t_rd_req           rd;
    ffha_pkg::t_wr_req           wr;
    logic [ffha_pkg::DATA_W-1:0] rdata;
    logic                        accept;
    logic                        cfg_wr;
    logic                        fits;
    logic                        can_split;
    logic                        out_range;

    ffha_store #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rd    (rd),
        .i_wr    (wr),
        .i_base  (r_base),
        .o_rdata (rdata)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign accept           = i_req.valid && i_req.ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.alloc_addr = r_out_addr;
    assign o_rsp.status     = r_out_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ffha_pkg::REG_BASE_ADDR);
    assign prdata = (paddr == ffha_pkg::REG_BASE_ADDR) ? r_base : '0;

    assign fits      = r_bsize >= r_size;
    assign can_split = {2'b00, r_bsize} >=
                       ({2'b00, r_size} + 34'(ffha_pkg::HDR_LEN) + 34'(ffha_pkg::SPLIT_SLACK));
    // range test without wrap
    assign out_range = ({1'b0, i_req.block_addr} < ({1'b0, r_base} + 33'(ffha_pkg::HDR_LEN))) ||
                       ({1'b0, i_req.block_addr} >= ({1'b0, r_base} + HEAP_SZ_X));

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_base       = r_base;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_size       = r_size;
        n_bsize      = r_bsize;
        n_nxt        = r_nxt;
        n_rem        = r_rem;
        n_steps      = r_steps;
        n_split      = r_split;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        rd           = '0;
        wr           = '0;

        if (cfg_wr) begin
            n_base = pwdata;
        end
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_addr   = '0;
                    n_res_status = ffha_pkg::STAT_OK;
                    case (i_req.cmd)
                        ffha_pkg::CMD_ALLOC: begin
                            n_size  = (i_req.req_size == '0) ? 32'd1 : i_req.req_size;
                            n_cur   = r_head;
                            n_prev  = '0;
                            n_steps = '0;
                            n_state = S_WALK;
                        end
                        ffha_pkg::CMD_FREE: begin
                            if (i_req.block_addr == '0) begin
                                n_state = S_DONE;
                            end else if (out_range) begin
                                n_res_status = ffha_pkg::STAT_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_cur   = i_req.block_addr - ffha_pkg::HDR_LEN;
                                n_state = S_F_RD;
                            end
                        end
                        ffha_pkg::CMD_INIT: begin
                            n_state = S_I_SIZE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_cur == '0 || r_steps >= STEP_MAX) begin
                    n_res_status = ffha_pkg::STAT_OOM;
                    n_state      = S_DONE;
                end else begin
                    rd.en   = 1'b1;
                    rd.addr = r_cur + ffha_pkg::OFF_SIZE;
                    n_steps = r_steps + 1'b1;
                    n_state = S_RD_NEXT;
                end
            end
            S_RD_NEXT: begin
                n_bsize = rdata;
                rd.en   = 1'b1;
                rd.addr = r_cur + ffha_pkg::OFF_NEXT;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_nxt = rdata;
                if (fits) begin
                    n_res_addr = r_cur + ffha_pkg::HDR_LEN;
                    // a payload address that wraps to zero still reports out of memory
                    n_res_status = (r_cur + ffha_pkg::HDR_LEN == '0) ?
                                   ffha_pkg::STAT_OOM : ffha_pkg::STAT_OK;
                    n_rem      = r_cur + ffha_pkg::HDR_LEN + r_size;
                    n_split    = can_split;
                    if (r_prev == '0) begin
                        n_head  = rdata;
                        n_state = can_split ? S_R_SIZE : S_C_USE;
                    end else begin
                        n_state = S_W_PREV;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = rdata;
                    n_state = S_WALK;
                end
            end
            S_W_PREV: begin
                wr.en   = 1'b1;
                wr.addr = r_prev + ffha_pkg::OFF_NEXT;
                wr.data = r_nxt;
                n_state = r_split ? S_R_SIZE : S_C_USE;
            end
            S_R_SIZE: begin
                wr.en   = 1'b1;
                wr.addr = r_rem + ffha_pkg::OFF_SIZE;
                wr.data = r_bsize - r_size - ffha_pkg::HDR_LEN;
                n_state = S_R_USE;
            end
            S_R_USE: begin
                wr.en   = 1'b1;
                wr.addr = r_rem + ffha_pkg::OFF_USE;
                wr.data = '0;
                n_state = S_R_NEXT;
            end
            S_R_NEXT: begin
                // remainder goes on the head of the list
                wr.en   = 1'b1;
                wr.addr = r_rem + ffha_pkg::OFF_NEXT;
                wr.data = r_head;
                n_head  = r_rem;
                n_state = S_C_SIZE;
            end
            S_C_SIZE: begin
                wr.en   = 1'b1;
                wr.addr = r_cur + ffha_pkg::OFF_SIZE;
                wr.data = r_size;
                n_state = S_C_USE;
            end
            S_C_USE: begin
                wr.en   = 1'b1;
                wr.addr = r_cur + ffha_pkg::OFF_USE;
                wr.data = 32'd1;
                n_state = S_DONE;
            end
            S_F_RD: begin
                rd.en   = 1'b1;
                rd.addr = r_cur + ffha_pkg::OFF_USE;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (rdata == '0) begin
                    n_res_status = ffha_pkg::STAT_BAD_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_F_USE;
                end
            end
            S_F_USE: begin
                wr.en   = 1'b1;
                wr.addr = r_cur + ffha_pkg::OFF_USE;
                wr.data = '0;
                n_state = S_F_NEXT;
            end
            S_F_NEXT: begin
                wr.en   = 1'b1;
                wr.addr = r_cur + ffha_pkg::OFF_NEXT;
                wr.data = r_head;
                n_head  = r_cur;
                n_state = S_DONE;
            end
            S_I_SIZE: begin
                wr.en   = 1'b1;
                wr.addr = r_base + ffha_pkg::OFF_SIZE;
                wr.data = INIT_SIZE;
                n_state = S_I_NEXT;
            end
            S_I_NEXT: begin
                wr.en   = 1'b1;
                wr.addr = r_base + ffha_pkg::OFF_NEXT;
                wr.data = '0;
                n_state = S_I_USE;
            end
            S_I_USE: begin
                wr.en   = 1'b1;
                wr.addr = r_base + ffha_pkg::OFF_USE;
                wr.data = '0;
                n_head  = r_base;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_base      <= ffha_pkg::BASE_ADDR_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_size       <= n_size;
        r_bsize      <= n_bsize;
        r_nxt        <= n_nxt;
        r_rem        <= n_rem;
        r_steps      <= n_steps;
        r_split      <= n_split;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the first-fit heap allocator: directed and random request streams.
`timescale 1ns / 1ps

module tb;

    localparam int HEAP     = 65536;
    localparam int WALK_MAX = HEAP / 12 + 1;
    localparam int SETTLE   = 16;
    localparam int PHASE_OPS = 200;
    localparam logic [ffha_pkg::CMD_W-1:0] CMD_NONE = 2'd3;    // unused code, ignored by the block

    typedef struct {
        bit [ffha_pkg::CMD_W-1:0]  cmd;
        bit [ffha_pkg::DATA_W-1:0] size;
        bit [ffha_pkg::DATA_W-1:0] ptr;
    } t_heap_op;

    typedef struct {
        bit [ffha_pkg::DATA_W-1:0] addr;
        bit [ffha_pkg::STAT_W-1:0] status;
    } t_heap_rsp;

    // Shadow heap plus queue of answers still owed by the block.
    class heap_scoreboard;
        bit [7:0]  mem [HEAP];
        bit        touched [HEAP];
        bit [31:0] head;
        bit [31:0] base;
        t_heap_rsp due [$];
        int n_err, n_beats, n_alloc, n_oom, n_free_ok, n_range, n_bad, n_init;

        function new();
            head = 0;
            base = ffha_pkg::BASE_ADDR_RST;
        endfunction

        function bit [31:0] rd_word(bit [31:0] hdr, bit [31:0] off, inout bit blind);
            bit [31:0] v;
            bit [31:0] r;
            v = 0;
            for (int i = 0; i < 4; i++) begin
                r = hdr + off + 32'(i) - base;
                if (r < HEAP) begin
                    if (!touched[r]) blind = 1'b1;
                    v |= 32'(mem[r]) << (8 * i);
                end
            end
            return v;
        endfunction

        function void wr_word(bit [31:0] hdr, bit [31:0] off, bit [31:0] v);
            bit [31:0] r;
            for (int i = 0; i < 4; i++) begin
                r = hdr + off + 32'(i) - base;
                if (r < HEAP) begin
                    mem[r]     = v[8*i +: 8];
                    touched[r] = 1'b1;
                end
            end
        endfunction

        function bit in_heap(bit [31:0] ptr);
            return 64'(ptr) >= 64'(base) + 64'(ffha_pkg::HDR_LEN) &&
                   64'(ptr) < 64'(base) + 64'(HEAP);
        endfunction

        // first-fit walk, read only; also reads the link of the hit as the unlink does
        function bit find_fit(bit [31:0] need, output bit [31:0] cur, output bit [31:0] prev,
                              inout bit blind);
            int steps;
            bit [31:0] bsize;
            prev  = 0;
            cur   = head;
            steps = 0;
            while (cur != 0 && steps < WALK_MAX) begin
                bsize = rd_word(cur, ffha_pkg::OFF_SIZE, blind);
                steps++;
                if (bsize >= need) begin
                    void'(rd_word(cur, ffha_pkg::OFF_NEXT, blind));
                    return 1'b1;
                end
                prev = cur;
                cur  = rd_word(cur, ffha_pkg::OFF_NEXT, blind);
            end
            return 1'b0;
        endfunction

        // true when the op would read a store byte never written since power-up
        function bit reads_blind(t_heap_op op);
            bit [31:0] cur;
            bit [31:0] prev;
            bit blind;
            blind = 1'b0;
            if (op.cmd == ffha_pkg::CMD_ALLOC)
                void'(find_fit(op.size == 0 ? 32'd1 : op.size, cur, prev, blind));
            else if (op.cmd == ffha_pkg::CMD_FREE && op.ptr != 0 && in_heap(op.ptr))
                void'(rd_word(op.ptr - ffha_pkg::HDR_LEN, ffha_pkg::OFF_USE, blind));
            return blind;
        endfunction

        function t_heap_rsp apply(t_heap_op op);
            t_heap_rsp res;
            bit [31:0] need, cur, prev, nxt, bsize, rem, hdr;
            bit blind;
            res.addr   = 0;
            res.status = ffha_pkg::STAT_OK;
            blind      = 1'b0;
            case (op.cmd)
                ffha_pkg::CMD_ALLOC: begin
                    need = (op.size == 0) ? 32'd1 : op.size;
                    if (find_fit(need, cur, prev, blind)) begin
                        bsize = rd_word(cur, ffha_pkg::OFF_SIZE, blind);
                        nxt   = rd_word(cur, ffha_pkg::OFF_NEXT, blind);
                        if (prev == 0) head = nxt;
                        else wr_word(prev, ffha_pkg::OFF_NEXT, nxt);
                        if (64'(bsize) >= 64'(need) + 64'(ffha_pkg::HDR_LEN) +
                                          64'(ffha_pkg::SPLIT_SLACK)) begin
                            rem = cur + ffha_pkg::HDR_LEN + need;
                            wr_word(rem, ffha_pkg::OFF_SIZE, bsize - need - ffha_pkg::HDR_LEN);
                            wr_word(rem, ffha_pkg::OFF_USE, 32'd0);
                            wr_word(rem, ffha_pkg::OFF_NEXT, head);
                            head = rem;
                            wr_word(cur, ffha_pkg::OFF_SIZE, need);
                        end
                        wr_word(cur, ffha_pkg::OFF_USE, 32'd1);
                        res.addr = cur + ffha_pkg::HDR_LEN;
                    end
                    res.status = (res.addr == 0) ? ffha_pkg::STAT_OOM : ffha_pkg::STAT_OK;
                end
                ffha_pkg::CMD_FREE: begin
                    if (op.ptr != 0) begin
                        if (!in_heap(op.ptr)) begin
                            res.status = ffha_pkg::STAT_RANGE;
                        end else begin
                            hdr = op.ptr - ffha_pkg::HDR_LEN;
                            if (rd_word(hdr, ffha_pkg::OFF_USE, blind) == 0) begin
                                res.status = ffha_pkg::STAT_BAD_FREE;
                            end else begin
                                wr_word(hdr, ffha_pkg::OFF_USE, 32'd0);
                                wr_word(hdr, ffha_pkg::OFF_NEXT, head);
                                head = hdr;
                            end
                        end
                    end
                end
                ffha_pkg::CMD_INIT: begin
                    wr_word(base, ffha_pkg::OFF_SIZE, HEAP - ffha_pkg::HDR_LEN);
                    wr_word(base, ffha_pkg::OFF_NEXT, 32'd0);
                    wr_word(base, ffha_pkg::OFF_USE, 32'd0);
                    head = base;
                end
                default: ;
            endcase
            return res;
        endfunction

        function t_heap_rsp note_input(t_heap_op op);
            t_heap_rsp res;
            res = apply(op);
            due.push_back(res);
            n_beats++;
            if (op.cmd == ffha_pkg::CMD_ALLOC) begin
                n_alloc++;
                if (res.status == ffha_pkg::STAT_OOM) n_oom++;
            end else if (op.cmd == ffha_pkg::CMD_FREE) begin
                if (res.status == ffha_pkg::STAT_RANGE) n_range++;
                else if (res.status == ffha_pkg::STAT_BAD_FREE) n_bad++;
                else if (op.ptr != 0) n_free_ok++;
            end else if (op.cmd == ffha_pkg::CMD_INIT) begin
                n_init++;
            end
            return res;
        endfunction

        function void check_result(logic [31:0] addr, logic [1:0] status);
            t_heap_rsp want;
            if (due.size() == 0) begin
                $display("%0t: result beat with nothing outstanding: addr %h status %0d",
                         $time, addr, status);
                n_err++;
                return;
            end
            want = due.pop_front();
            if (addr !== want.addr) begin
                $display("%0t: alloc_addr expected %h got %h", $time, want.addr, addr);
                n_err++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
                n_err++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ffha_pkg::PADDR_W-1:0]   paddr;
    logic [ffha_pkg::DATA_W-1:0]    pwdata;
    logic [ffha_pkg::DATA_W-1:0]    prdata;
    logic                           pready;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator #(.HEAP_BYTES(HEAP)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    heap_scoreboard sb = new();
    bit [31:0] live [$];       // payloads currently handed out
    bit [31:0] gone [$];       // recently freed payloads, for double frees
    bit        calm = 1'b0;    // no idling on either side while set
    int        stall_left = 0;
    int        n_bases = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000_000;
        $display("%0t: timed out with %0d results outstanding", $time, sb.due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // result side: check each beat, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.alloc_addr, rsp_ch.status);
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
        end
    end

    task automatic send(t_heap_op op);
        t_heap_rsp res;
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.cmd        <= op.cmd;
        req_ch.req_size   <= op.size;
        req_ch.block_addr <= op.ptr;
        req_ch.valid      <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        res = sb.note_input(op);
        if (op.cmd == ffha_pkg::CMD_INIT) begin
            live.delete();
            gone.delete();
        end else if (op.cmd == ffha_pkg::CMD_ALLOC && res.status == ffha_pkg::STAT_OK) begin
            live.push_back(res.addr);
        end else if (op.cmd == ffha_pkg::CMD_FREE && res.status == ffha_pkg::STAT_OK &&
                     op.ptr != 0) begin
            for (int i = 0; i < live.size(); i++)
                if (live[i] == op.ptr) begin
                    live.delete(i);
                    break;
                end
            gone.push_back(op.ptr);
            if (gone.size() > 16) void'(gone.pop_front());
        end
    endtask

    task automatic issue(bit [ffha_pkg::CMD_W-1:0] c, bit [31:0] s, bit [31:0] p);
        t_heap_op op;
        op.cmd  = c;
        op.size = s;
        op.ptr  = p;
        send(op);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write the base address register, then read it back
    task automatic set_base(bit [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ffha_pkg::REG_BASE_ADDR;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.base = val;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== val) begin
            $display("%0t: base address read back expected %h got %h", $time, val, prdata);
            sb.n_err++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        live.delete();
        gone.delete();
        n_bases++;
    endtask

    function automatic bit [31:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 64);
        if (r < 78) return $urandom_range(65, 1024);
        if (r < 90) return $urandom_range(1025, 20000);
        if (r < 95) return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 40);
    endfunction

    function automatic t_heap_op rand_op();
        t_heap_op op;
        int pick;
        op.cmd  = ffha_pkg::CMD_ALLOC;
        op.size = $urandom;     // fields the command ignores still toggle
        op.ptr  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 80 && live.size() == 0)) begin
            op.size = rand_size();
        end else if (pick < 80) begin
            op.cmd = ffha_pkg::CMD_FREE;
            op.ptr = live[$urandom_range(0, live.size() - 1)];
        end else if (pick < 86) begin
            op.cmd = ffha_pkg::CMD_FREE;
            op.ptr = (gone.size() == 0) ? 32'd0 : gone[$urandom_range(0, gone.size() - 1)];
        end else if (pick < 91) begin
            op.cmd = ffha_pkg::CMD_FREE;
            op.ptr = sb.base + $urandom_range(0, HEAP - 1);
        end else if (pick < 94) begin
            op.cmd = ffha_pkg::CMD_FREE;
            if ($urandom_range(0, 1) == 0) op.ptr = 0;
        end else if (pick < 97) begin
            op.cmd = ffha_pkg::CMD_INIT;
        end else begin
            op.cmd = CMD_NONE;
        end
        return op;
    endfunction

    task automatic run_phase(int count);
        t_heap_op op;
        int tries;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) calm <= !calm;
            if (n == count / 2) settle();
            op = rand_op();
            tries = 0;
            // never touch store bytes that hold power-up garbage
            while (sb.reads_blind(op) && tries < 16) begin
                op = rand_op();
                tries++;
            end
            if (sb.reads_blind(op)) op.cmd = ffha_pkg::CMD_INIT;
            send(op);
        end
    endtask

    initial begin
        bit [31:0] b;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = ffha_pkg::CMD_ALLOC;
        req_ch.req_size   = '0;
        req_ch.block_addr = '0;
        rsp_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = ffha_pkg::REG_BASE_ADDR;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        b = ffha_pkg::BASE_ADDR_RST;
        issue(ffha_pkg::CMD_ALLOC, 32'd5, 32'd0);                 // empty list before init
        issue(ffha_pkg::CMD_FREE, 32'd0, 32'd0);                  // free of null
        issue(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(ffha_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFFF);
        issue(ffha_pkg::CMD_INIT, 32'd0, 32'd0);
        issue(ffha_pkg::CMD_ALLOC, 32'd0, 32'd0);                 // zero size rounds up to one
        issue(ffha_pkg::CMD_FREE, 32'd0, b + 12);
        issue(ffha_pkg::CMD_FREE, 32'd0, b + 12);                 // double free
        issue(ffha_pkg::CMD_FREE, 32'd0, b + 11);
        issue(ffha_pkg::CMD_FREE, 32'd0, b + HEAP);
        issue(ffha_pkg::CMD_ALLOC, 32'd40, 32'd0);
        issue(ffha_pkg::CMD_ALLOC, 32'd8, 32'd0);
        issue(ffha_pkg::CMD_FREE, 32'd0, b + 25);
        issue(ffha_pkg::CMD_ALLOC, 32'd30, 32'd0);                // leftover too small to split
        issue(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFEC, 32'd0);         // size sum must not wrap
        issue(ffha_pkg::CMD_INIT, 32'd0, 32'd0);
        issue(ffha_pkg::CMD_ALLOC, HEAP - 12, 32'd0);             // whole heap
        issue(ffha_pkg::CMD_ALLOC, 32'd1, 32'd0);
        issue(ffha_pkg::CMD_FREE, 32'd0, b + 12);
        issue(ffha_pkg::CMD_ALLOC, HEAP - 32, 32'd0);             // leftover exactly split threshold
        issue(ffha_pkg::CMD_ALLOC, 32'd8, 32'd0);
        issue(ffha_pkg::CMD_ALLOC, HEAP - 11, 32'd0);
        run_phase(PHASE_OPS);

        settle();
        set_base(32'd4);
        issue(ffha_pkg::CMD_INIT, 32'd0, 32'd0);
        run_phase(PHASE_OPS);

        settle();
        set_base(32'hFFFF_0000);
        issue(ffha_pkg::CMD_INIT, 32'd0, 32'd0);
        run_phase(PHASE_OPS);

        // shift the base under a live list: old headers now land elsewhere in the store
        settle();
        set_base(32'hFFFF_0000 - 32'h40);
        run_phase(PHASE_OPS);

        settle();
        set_base($urandom_range(4, 32'hFFFF_0000));
        issue(ffha_pkg::CMD_INIT, 32'd0, 32'd0);
        run_phase(PHASE_OPS);

        settle();
        set_base(ffha_pkg::BASE_ADDR_RST);
        issue(ffha_pkg::CMD_INIT, 32'd0, 32'd0);
        run_phase(PHASE_OPS);

        settle();
        $display("covered %0d request beats over %0d base addresses",
                 sb.n_beats, n_bases);
        $display("allocations: %0d, %0d out of memory; %0d inits",
                 sb.n_alloc, sb.n_oom, sb.n_init);
        $display("frees: %0d accepted, %0d outside heap, %0d double or invalid; %0d mismatches",
                 sb.n_free_ok, sb.n_range, sb.n_bad, sb.n_err);
        if (sb.n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
